// ===== src/assert_macros.svh =====
// Assertion macros used by the late-acceptance filter controller.
// Define ASSERT_OFF to compile every assertion out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an implication property on the rising clock edge, outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds on the rising clock edge, outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/lafu_pkg.sv =====
// Package of the late-acceptance filter: widths, register indexes,
// controller states and the controller-to-datapath command struct. No dependencies.
package lafu_pkg;

	localparam int MAX_HISTORY_DEF = 256;
	localparam int COST_W          = 32;
	localparam int ITER_W          = 32;
	localparam int HLEN_W          = 9;
	localparam int CFG_IDX_W       = 2;
	localparam int DIV_STEPS       = ITER_W;
	localparam int STEP_CNT_W      = $clog2(DIV_STEPS);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COST = 2'd2;

	localparam logic [HLEN_W-1:0] HLEN_RESET = 9'd256;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_READ,
		ST_DECIDE
	} lafu_state_t;

	typedef struct packed {
		logic load;      // capture request payload, start modulo
		logic div_step;  // one restoring-division step
		logic rd_en;     // read history slot
		logic commit;    // decide, update state, load result register
	} lafu_cmd_t;

endpackage

// ===== src/lafu_if.sv =====
// Handshake channels of the late-acceptance filter: candidate request and result.
// Depends on lafu_pkg for field widths.
interface lafu_req_if import lafu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [COST_W-1:0] current_cost;
	logic signed [COST_W-1:0] candidate_cost;
	logic        [ITER_W-1:0] iteration;

	modport source (output valid, current_cost, candidate_cost, iteration, input ready);
	modport sink (input valid, current_cost, candidate_cost, iteration, output ready);
endinterface

interface lafu_res_if import lafu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     accepted;
	logic                     improved_best;
	logic signed [COST_W-1:0] best_so_far;

	modport source (output valid, accepted, improved_best, best_so_far, input ready);
	modport sink (input valid, accepted, improved_best, best_so_far, output ready);
endinterface

// ===== src/late_acceptance_filter_unit.sv =====
// Late-acceptance hill-climbing filter, top level. Uses lafu_pkg, lafu_if, lafu_ctrl, lafu_dp.
// Flow: an accepted request runs the bit-serial iteration-modulo-length divider,
// then one history RAM read and one decision, which waits while the result register is full.
// One request at a time: the next is taken once the last is decided, also while its result waits.
// Reset: arst_n clears control, slot valid bits, best flag and config registers; no clearing pass.
module late_acceptance_filter_unit import lafu_pkg::*; #(
	parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lafu_req_if.sink             cand_req,
	lafu_res_if.source           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COST_W-1:0]    cfg_data
);

	lafu_cmd_t cmd;

	lafu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cand_req.valid),
		.in_ready  (cand_req.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	lafu_dp #(
		.MAX_HISTORY (MAX_HISTORY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.current_cost   (cand_req.current_cost),
		.candidate_cost (cand_req.candidate_cost),
		.iteration      (cand_req.iteration),
		.accepted       (result.accepted),
		.improved_best  (result.improved_best),
		.best_so_far    (result.best_so_far)
	);

endmodule

// ===== src/lafu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lafu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/lafu_ctrl.sv =====
// Controller of the late-acceptance filter: sequences capture, modulo,
// history read and decision; owns the result valid flag. Uses lafu_pkg.
`include "assert_macros.svh"
module lafu_ctrl import lafu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output lafu_cmd_t cmd
);

	lafu_state_t             state_q, state_d;
	logic [STEP_CNT_W-1:0]   step_q;
	logic                    out_valid_q;

	// State register, step counter, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= cmd.div_step ? step_q + 1'b1 : '0;
			out_valid_q <= cmd.commit | (out_valid_q & ~out_ready);
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				// hold the decision until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.commit && out_valid_q && !out_ready, "result overwritten before taken")
	`ASSERT_CLK(a_accept_starts_div, clk, arst_n, (in_valid && in_ready) |=> (state_q == ST_DIVIDE && step_q == '0), "accepted request did not start modulo")
	`ASSERT_CLK(a_div_len, clk, arst_n, (state_q == ST_DIVIDE && step_q == STEP_CNT_W'(DIV_STEPS - 1)) |=> (state_q == ST_READ), "modulo did not end after its last step")
	`ASSERT_NEVER(a_one_cmd, clk, arst_n, !$onehot0({cmd.load, cmd.div_step, cmd.rd_en, cmd.commit}), "more than one command at once")

endmodule

// ===== src/lafu_dp.sv =====
// Datapath of the late-acceptance filter: configuration registers, bit-serial
// modulo, history RAM with valid bits, acceptance decision, best cost and result
// register. Uses lafu_pkg and lafu_ram.
module lafu_dp import lafu_pkg::*; #(
	parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lafu_cmd_t                cmd,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [COST_W-1:0]        cfg_data,
	input  logic signed [COST_W-1:0] current_cost,
	input  logic signed [COST_W-1:0] candidate_cost,
	input  logic [ITER_W-1:0]        iteration,
	output logic                     accepted,
	output logic                     improved_best,
	output logic signed [COST_W-1:0] best_so_far
);

	localparam int LEN_W  = $clog2(MAX_HISTORY + 1);
	localparam int SLOT_W = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;

	logic                     maximize_q;
	logic [HLEN_W-1:0]        hlen_q;
	logic signed [COST_W-1:0] init_cost_q;

	logic signed [COST_W-1:0] cur_q, cand_q;
	logic [ITER_W-1:0]        dividend_q;
	logic [LEN_W-1:0]         rem_q;
	logic [LEN_W-1:0]         len_eff;
	logic [LEN_W:0]           rem_sh, rem_sub;
	logic [SLOT_W-1:0]        slot;

	logic [MAX_HISTORY-1:0]   slot_valid_q;
	logic [COST_W-1:0]        hist_rdata;
	logic signed [COST_W-1:0] best_q;
	logic                     best_set_q;

	logic signed [COST_W-1:0] late_cost, best_cur;
	logic                     reject, beats_best;

	logic                     accepted_q, improved_q;
	logic signed [COST_W-1:0] best_out_q;

	function automatic logic is_better(input logic maxi, input logic signed [COST_W-1:0] a,
		input logic signed [COST_W-1:0] b);
		return maxi ? (a > b) : (a < b);
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maximize_q  <= 1'b0;
			hlen_q      <= HLEN_RESET;
			init_cost_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAXIMIZE:     maximize_q  <= cfg_data[0];
				CFG_HISTORY_LEN:  hlen_q      <= cfg_data[HLEN_W-1:0];
				CFG_INITIAL_COST: init_cost_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp a zero or oversized history length to the full depth
	always_comb begin
		if (hlen_q == '0 || 32'(hlen_q) > 32'(MAX_HISTORY)) begin
			len_eff = LEN_W'(MAX_HISTORY);
		end else begin
			len_eff = LEN_W'(hlen_q);
		end
	end

	// One restoring-division step: shift in the next iteration bit
	assign rem_sh  = {rem_q, dividend_q[ITER_W-1]};
	assign rem_sub = rem_sh - {1'b0, len_eff};
	assign slot    = rem_q[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q      <= current_cost;
			cand_q     <= candidate_cost;
			dividend_q <= iteration;
			rem_q      <= '0;
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[ITER_W-2:0], 1'b0};
			rem_q      <= (rem_sh >= {1'b0, len_eff}) ? rem_sub[LEN_W-1:0]
			                                          : rem_sh[LEN_W-1:0];
		end
	end

	lafu_ram #(
		.WIDTH (COST_W),
		.DEPTH (MAX_HISTORY)
	) u_hist (
		.clk   (clk),
		.we    (cmd.commit && !reject),
		.waddr (slot),
		.wdata (cand_q),
		.re    (cmd.rd_en),
		.raddr (slot),
		.rdata (hist_rdata)
	);

	// Decision: reject only a candidate worse than both current and late cost
	always_comb begin
		late_cost  = slot_valid_q[slot] ? signed'(hist_rdata) : init_cost_q;
		best_cur   = best_set_q ? best_q : init_cost_q;
		reject     = is_better(maximize_q, cur_q, cand_q) &&
		             is_better(maximize_q, late_cost, cand_q);
		beats_best = !reject && is_better(maximize_q, cand_q, best_cur);
	end

	// Valid bits and best-cost flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			best_set_q   <= 1'b0;
		end else if (cmd.commit) begin
			if (!reject) begin
				slot_valid_q[slot] <= 1'b1;
			end
			if (beats_best) begin
				best_set_q <= 1'b1;
			end
		end
	end

	// Best cost and result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (beats_best) begin
				best_q <= cand_q;
			end
			accepted_q <= !reject;
			improved_q <= beats_best;
			best_out_q <= beats_best ? cand_q : best_cur;
		end
	end

	assign accepted      = accepted_q;
	assign improved_best = improved_q;
	assign best_so_far   = best_out_q;

endmodule

// ===== bench/tb_top.sv =====
// Testbench of late_acceptance_filter_unit: directed requests, then random cost walks
// under changing registers, each result checked against a cycle-free acceptance predictor.
// Depends on lafu_pkg, lafu_req_if and lafu_res_if from the RTL.
module tb_top import lafu_pkg::*; ();

	localparam int SLOTS = MAX_HISTORY_DEF;
	// Register index past the end of the register list; writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic signed [COST_W-1:0] COST_MIN = 32'sh8000_0000;
	localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic                     accepted;
		logic                     improved;
		logic signed [COST_W-1:0] best;
	} outcome_t;

	// Acceptance predictor plus queue of outcomes still owed by the block
	class acceptance_board;
		logic                     maximize;
		logic [HLEN_W-1:0]        hist_len;
		logic signed [COST_W-1:0] initial_cost;
		logic signed [COST_W-1:0] history [SLOTS];
		bit                       written [SLOTS];
		logic signed [COST_W-1:0] record_cost;
		bit                       best_set;
		outcome_t                 owed [$];
		int                       mismatches;

		function new();
			maximize = 1'b0;
			hist_len = HLEN_RESET;
			initial_cost = '0;
			record_cost = '0;
			best_set = 1'b0;
			mismatches = 0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] data);
			case (idx)
				CFG_MAXIMIZE: maximize = data[0];
				CFG_HISTORY_LEN: hist_len = data[HLEN_W-1:0];
				CFG_INITIAL_COST: initial_cost = data;
				default: ;
			endcase
		endfunction

		function bit is_better(logic signed [COST_W-1:0] a, logic signed [COST_W-1:0] b);
			return maximize ? (a > b) : (a < b);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Predict one request; returns whether the candidate is taken
		function bit note_request(logic signed [COST_W-1:0] cur, logic signed [COST_W-1:0] cand,
				logic [ITER_W-1:0] iter);
			int unsigned len;
			int unsigned slot;
			logic signed [COST_W-1:0] late;
			logic signed [COST_W-1:0] best;
			outcome_t o;
			len = (hist_len == 0 || hist_len > SLOTS) ? SLOTS : hist_len;
			slot = iter % len;
			late = written[slot] ? history[slot] : initial_cost;
			best = best_set ? record_cost : initial_cost;
			o.accepted = !(is_better(cur, cand) && is_better(late, cand));
			o.improved = 1'b0;
			if (o.accepted) begin
				history[slot] = cand;
				written[slot] = 1'b1;
				if (is_better(cand, best)) begin
					best = cand;
					record_cost = cand;
					best_set = 1'b1;
					o.improved = 1'b1;
				end
			end
			o.best = best;
			owed.push_back(o);
			return o.accepted;
		endfunction

		task report(string what);
			if (mismatches < 50)
				$display("check failed at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_result(logic acc, logic imp, logic signed [COST_W-1:0] best);
			outcome_t o;
			if (owed.size() == 0) begin
				report("result arrived with nothing owed");
				return;
			end
			o = owed.pop_front();
			if (acc !== o.accepted)
				report($sformatf("accepted %b, predicted %b", acc, o.accepted));
			if (imp !== o.improved)
				report($sformatf("improved_best %b, predicted %b", imp, o.improved));
			if (best !== o.best)
				report($sformatf("best_so_far %0d, predicted %0d", best, o.best));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COST_W-1:0]    cfg_data;

	lafu_req_if req_ch ();
	lafu_res_if res_ch ();

	acceptance_board board;
	bit  steady;
	bit  last_taken;
	int  stall_left;

	late_acceptance_filter_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand_req  (req_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Idle length: mostly short, now and then long
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 4);
		if (r < 95)
			return $urandom_range(5, 40);
		return $urandom_range(41, 120);
	endfunction

	// Check each accepted result, then pick the next ready level
	always @(posedge clk) begin
		if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			board.check_result(res_ch.accepted, res_ch.improved_best, res_ch.best_so_far);
		if (arst_n && stall_left == 0 && !steady && $urandom_range(0, 99) < 20)
			stall_left = gap_length();
		res_ch.ready <= (stall_left == 0);
		if (stall_left > 0)
			stall_left--;
	end

	// Offer one request after a random gap and hold it until taken
	task automatic send(input logic signed [COST_W-1:0] cur, input logic signed [COST_W-1:0] cand,
			input logic [ITER_W-1:0] iter);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 50) ? 0 : gap_length();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.current_cost <= cur;
		req_ch.candidate_cost <= cand;
		req_ch.iteration <= iter;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		last_taken = board.note_request(cur, cand, iter);
	endtask

	// Drop valid and hold until every owed result is back
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [COST_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		board.write_register(idx, data);
	endtask

	task automatic set_config(input logic maxim, input logic [COST_W-1:0] hlen,
			input logic [COST_W-1:0] init);
		write_register(CFG_MAXIMIZE, {31'd0, maxim});
		write_register(CFG_HISTORY_LEN, hlen);
		write_register(CFG_INITIAL_COST, init);
		cfg_we <= 1'b0;
	endtask

	// Random walk of a search: mostly sequential iterations, current follows accepts
	task automatic run_random_phase(input int count);
		logic signed [COST_W-1:0] cur;
		logic signed [COST_W-1:0] cand;
		logic [ITER_W-1:0] iter;
		int pick;
		cur = $urandom();
		iter = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom();
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				cand = $urandom();
			else if (pick < 15)
				cand = cur;
			else if (pick < 20)
				cand = pick[0] ? COST_MAX : COST_MIN;
			else
				cand = cur + $signed($urandom_range(0, 2000)) - 1000;
			if ($urandom_range(0, 99) < 5)
				iter = $urandom();
			else
				iter = iter + 1;
			if ($urandom_range(0, 99) < 8)
				cur = $urandom();
			send(cur, cand, iter);
			if (last_taken)
				cur = cand;
		end
	endtask

	initial begin : stimulus
		logic [COST_W-1:0] hlen_val;
		logic [COST_W-1:0] init_val;
		board = new();
		steady = 1'b0;
		stall_left = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.current_cost <= '0;
		req_ch.candidate_cost <= '0;
		req_ch.iteration <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: equal, rejected, late-accepted and extreme requests
		send(5, 5, 0);
		send(0, 10, 1);
		send(0, 3, 0);
		send(COST_MAX, COST_MAX, 32'hFFFF_FFFF);

		// Best still follows the live initial cost; unwritten slot reads it too
		settle();
		write_register(CFG_INITIAL_COST, 32'd20);
		cfg_we <= 1'b0;
		send(0, 10, 1);
		send(COST_MIN, 0, 2);
		send(100, COST_MIN, 32'hFFFF_FFFF);
		send(COST_MIN, COST_MAX, 255);
		send(0, 0, 256);

		// Maximize with a single slot and the top initial cost
		settle();
		set_config(1'b1, 32'd1, COST_MAX);
		send(0, -5, 12345);
		send(0, 5, 7);
		send(10, COST_MAX, 0);
		send(COST_MAX, COST_MIN, 32'hFFFF_FFFF);

		// Zero length means full size; unmapped index is dropped
		settle();
		write_register(CFG_HISTORY_LEN, 32'd0);
		write_register(CFG_UNMAPPED, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;
		send(0, 1, 1);
		send(5, 3, 257);

		// Oversized lengths clamp to full size
		settle();
		write_register(CFG_MAXIMIZE, 32'd0);
		write_register(CFG_HISTORY_LEN, 32'd511);
		cfg_we <= 1'b0;
		send(3, 4, 513);
		settle();
		write_register(CFG_HISTORY_LEN, 32'd257);
		cfg_we <= 1'b0;
		send(0, 0, 32'h8000_0000);
		settle();
		set_config(1'b0, 32'd2, COST_MIN);
		send(1, 2, 3);
		send(2, 1, 4);

		// Random phases, each under fresh registers; one runs with no idling
		for (int p = 0; p < 7; p++) begin
			settle();
			case (p)
				0: hlen_val = 32'd1;
				1: hlen_val = 32'd256;
				2: hlen_val = 32'd0;
				3: hlen_val = 32'd511;
				4: hlen_val = $urandom_range(2, 16);
				5: hlen_val = $urandom_range(1, 256);
				default: hlen_val = $urandom_range(257, 510);
			endcase
			init_val = (p == 0) ? COST_MIN : (p == 1) ? COST_MAX : $urandom();
			set_config(1'($urandom_range(0, 1)), hlen_val, init_val);
			steady = (p == 3);
			run_random_phase(150);
			steady = 1'b0;
		end

		settle();
		repeat (40) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hang guard
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
